// ===== rtl/core/ece_pkg.sv =====
// Package for the easing curve evaluator: fixed-point constants, curve codes,
// the quarter-wave sine table and the record that travels down the square-root chain.
// No dependencies.
package ece_pkg;

	localparam int FRAC_BITS  = 16;
	localparam int FIELD_W    = 17;
	localparam int SINE_DEPTH = 256;
	localparam int SINE_SHIFT = $clog2(2 * SINE_DEPTH);
	localparam int ROM_AW     = $clog2(SINE_DEPTH + 1);
	localparam int RAD_W      = 30;
	localparam int ROOT_STEPS = RAD_W / 2;
	localparam int CFG_AW     = 3;

	localparam logic [FIELD_W-1:0] ONE_Q      = FIELD_W'(1 << FRAC_BITS);
	localparam logic [FIELD_W-1:0] HALF_Q     = FIELD_W'(1 << (FRAC_BITS - 1));
	localparam logic [FIELD_W-1:0] Q3_Q       = FIELD_W'(3 << (FRAC_BITS - 2));
	localparam logic [FIELD_W-1:0] OUT_MAX    = {FIELD_W{1'b1}};
	localparam logic [RAD_W-1:0]   BOUNCE_R2  = RAD_W'(64'd5 << (2 * FRAC_BITS - 6));
	localparam logic [RAD_W-1:0]   BOUNCE_OFS = RAD_W'(64'd7 << (FRAC_BITS - 3));
	localparam logic [63:0]        PI_HALF_Q30 = 64'd1686629713;

	typedef enum logic [2:0] {
		CURVE_LINEAR      = 3'd0,
		CURVE_CONSTANT    = 3'd1,
		CURVE_BOUNCE      = 3'd2,
		CURVE_FADE_IN     = 3'd3,
		CURVE_FADE_OUT    = 3'd4,
		CURVE_FADE_IN_OUT = 3'd5
	} curve_mode_t;

	typedef logic [FIELD_W-1:0] sine_rom_t [0:SINE_DEPTH];

	typedef struct packed {
		logic [RAD_W-1:0]   rem;
		logic [RAD_W-1:0]   root;
		logic [FIELD_W-1:0] result;
		logic               use_sqrt;
	} cell_t;

	// Each entry is a 9-term Taylor series in Q30, rounded to the output format.
	function automatic sine_rom_t build_sine_rom();
		sine_rom_t          rom;
		logic [63:0]        x;
		logic [63:0]        x2;
		logic [63:0]        term;
		logic signed [63:0] s;
		for (int k = 0; k <= SINE_DEPTH; k++) begin
			x    = (PI_HALF_Q30 * 64'(k)) / SINE_DEPTH;
			x2   = (x * x) >> 30;
			term = x;
			s    = signed'(x);
			term = ((term * x2) >> 30) / 6;
			s    = s - signed'(term);
			term = ((term * x2) >> 30) / 20;
			s    = s + signed'(term);
			term = ((term * x2) >> 30) / 42;
			s    = s - signed'(term);
			term = ((term * x2) >> 30) / 72;
			s    = s + signed'(term);
			term = ((term * x2) >> 30) / 110;
			s    = s - signed'(term);
			term = ((term * x2) >> 30) / 156;
			s    = s + signed'(term);
			term = ((term * x2) >> 30) / 210;
			s    = s - signed'(term);
			term = ((term * x2) >> 30) / 272;
			s    = s + signed'(term);
			if (s < 0) begin
				s = 0;
			end
			rom[k] = FIELD_W'((unsigned'(s) + (64'd1 << (29 - FRAC_BITS))) >> (30 - FRAC_BITS));
		end
		return rom;
	endfunction

	localparam sine_rom_t SINE_ROM = build_sine_rom();

endpackage

// ===== rtl/core/ece_front.sv =====
// Front pipeline of the easing curve evaluator: clamps the time, forms the products,
// reads the sine table and resolves every curve except the bounce arc's square root.
// Depends on ece_pkg.
module ece_front (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          time_valid,
	output logic                          time_stall,
	input  logic [ece_pkg::FIELD_W-1:0]   progress_time,
	input  logic [2:0]                    curve_mode,
	output logic                          cell_valid,
	input  logic                          cell_stall,
	output ece_pkg::cell_t                cell_data
);

	localparam int F  = ece_pkg::FRAC_BITS;
	localparam int W  = ece_pkg::FIELD_W;
	localparam int AW = ece_pkg::ROM_AW;

	logic v_s1, v_s2, v_s3, v_s4, v_s5;
	logic st1, st2, st3, st4, st5;

	logic [W-1:0] t_s1;
	logic [2:0]   mode_s1;

	logic [2*W-2:0] sq_s2;
	logic [2*W-2:0] fo_s2;
	logic [2*F-1:0] dd_s2;
	logic [AW-1:0]  k_s2;
	logic [F-1:0]   f_s2;
	logic [W-1:0]   t_s2;
	logic [2:0]     mode_s2;
	logic           hi_s2;

	logic [W-1:0]               res_s3, e0_s3, diff_s3;
	logic [ece_pkg::RAD_W-1:0]  rad_s3;
	logic [F-1:0]               f_s3;
	logic                       sqrt_s3, sine_s3, hi_s3;

	logic [W+F-1:0]             prod_s4;
	logic [W-1:0]               res_s4, e0_s4;
	logic [ece_pkg::RAD_W-1:0]  rad_s4;
	logic                       sqrt_s4, sine_s4, hi_s4;

	ece_pkg::cell_t data_s5;

	logic [W-1:0]             t_c;
	logic [F-1:0]             d, a;
	logic [W:0]               two_minus_t;
	logic [AW-1:0]            k1;
	logic [W-1:0]             e0, e1, diff;
	logic [W-1:0]             res_n;
	logic [W-1:0]             fin_n, fout_n;
	logic [ece_pkg::RAD_W-1:0] rad_n;
	logic [W+F:0]             rnd;
	logic [W+1:0]             s_sum;
	logic [W-1:0]             s_c;
	logic [W+1:0]             fio;

	assign st5 = v_s5 && cell_stall;
	assign st4 = v_s4 && st5;
	assign st3 = v_s3 && st4;
	assign st2 = v_s2 && st3;
	assign st1 = v_s1 && st2;
	assign time_stall = st1;

	assign t_c = (progress_time > ece_pkg::ONE_Q) ? ece_pkg::ONE_Q : progress_time;

	always_comb begin
		d = (t_s1 >= ece_pkg::Q3_Q) ? F'(t_s1 - ece_pkg::Q3_Q) : F'(ece_pkg::Q3_Q - t_s1);
		a = (t_s1 >= ece_pkg::HALF_Q) ? F'(t_s1 - ece_pkg::HALF_Q) : F'(ece_pkg::HALF_Q - t_s1);
		two_minus_t = (W+1)'({ece_pkg::ONE_Q, 1'b0}) - (W+1)'(t_s1);
	end

	always_comb begin
		k1     = (k_s2 == AW'(ece_pkg::SINE_DEPTH)) ? k_s2 : AW'(k_s2 + AW'(1));
		e0     = ece_pkg::SINE_ROM[k_s2];
		e1     = ece_pkg::SINE_ROM[k1];
		diff   = (e1 >= e0) ? W'(e1 - e0) : '0;
		fin_n  = W'(((2*W)'(sq_s2) + (2*W)'(ece_pkg::HALF_Q)) >> F);
		fout_n = W'(((2*W)'(fo_s2) + (2*W)'(ece_pkg::HALF_Q)) >> F);
		rad_n  = (ece_pkg::BOUNCE_R2 > ece_pkg::RAD_W'(dd_s2)) ?
			ece_pkg::RAD_W'(ece_pkg::BOUNCE_R2 - ece_pkg::RAD_W'(dd_s2)) : '0;
		unique case (mode_s2)
			ece_pkg::CURVE_CONSTANT: res_n = ece_pkg::ONE_Q;
			ece_pkg::CURVE_BOUNCE:   res_n = W'({t_s2, 1'b0});
			ece_pkg::CURVE_FADE_IN:  res_n = fin_n;
			ece_pkg::CURVE_FADE_OUT: res_n = fout_n;
			default:                 res_n = t_s2;
		endcase
	end

	always_comb begin
		rnd   = (W+F+1)'(prod_s4) + (W+F+1)'(ece_pkg::HALF_Q);
		s_sum = (W+2)'(e0_s4) + (W+2)'(rnd >> F);
		s_c   = (s_sum > (W+2)'(ece_pkg::ONE_Q)) ? ece_pkg::ONE_Q : W'(s_sum);
		if (hi_s4) begin
			fio = ((W+2)'(ece_pkg::ONE_Q) + (W+2)'(s_c) + (W+2)'(1)) >> 1;
		end else begin
			fio = ((W+2)'(ece_pkg::ONE_Q) - (W+2)'(s_c) + (W+2)'(1)) >> 1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
		end else begin
			if (!st1) v_s1 <= time_valid;
			if (!st2) v_s2 <= v_s1;
			if (!st3) v_s3 <= v_s2;
			if (!st4) v_s4 <= v_s3;
			if (!st5) v_s5 <= v_s4;
		end
	end

	always_ff @(posedge clk) begin
		if (!st1 && time_valid) begin
			t_s1    <= t_c;
			mode_s1 <= curve_mode;
		end
		if (!st2 && v_s1) begin
			sq_s2   <= (2*W-1)'((2*W)'(t_s1) * (2*W)'(t_s1));
			fo_s2   <= (2*W-1)'((2*W+1)'(t_s1) * (2*W+1)'(two_minus_t));
			dd_s2   <= (2*F)'(d) * (2*F)'(d);
			k_s2    <= AW'(a >> (F - ece_pkg::SINE_SHIFT));
			f_s2    <= F'({a, {ece_pkg::SINE_SHIFT{1'b0}}});
			t_s2    <= t_s1;
			mode_s2 <= mode_s1;
			hi_s2   <= (t_s1 >= ece_pkg::HALF_Q);
		end
		if (!st3 && v_s2) begin
			res_s3  <= res_n;
			e0_s3   <= e0;
			diff_s3 <= diff;
			rad_s3  <= rad_n;
			f_s3    <= f_s2;
			sqrt_s3 <= (mode_s2 == ece_pkg::CURVE_BOUNCE) && hi_s2;
			sine_s3 <= (mode_s2 == ece_pkg::CURVE_FADE_IN_OUT);
			hi_s3   <= hi_s2;
		end
		if (!st4 && v_s3) begin
			prod_s4 <= (W+F)'(diff_s3) * (W+F)'(f_s3);
			res_s4  <= res_s3;
			e0_s4   <= e0_s3;
			rad_s4  <= rad_s3;
			sqrt_s4 <= sqrt_s3;
			sine_s4 <= sine_s3;
			hi_s4   <= hi_s3;
		end
		if (!st5 && v_s4) begin
			data_s5.rem      <= rad_s4;
			data_s5.root     <= '0;
			data_s5.result   <= sine_s4 ? W'(fio) : res_s4;
			data_s5.use_sqrt <= sqrt_s4;
		end
	end

	assign cell_valid = v_s5;
	assign cell_data  = data_s5;

endmodule

// ===== rtl/core/ece_sqrt_cell.sv =====
// One cell of the square-root chain: settles one root bit from two radicand bits
// and hands the partial remainder, root and carried result to the next cell.
// Depends on ece_pkg.
module ece_sqrt_cell (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic [ece_pkg::RAD_W-1:0]   step_bit,
	input  logic                        up_valid,
	output logic                        up_stall,
	input  ece_pkg::cell_t              up_data,
	output logic                        dn_valid,
	input  logic                        dn_stall,
	output ece_pkg::cell_t              dn_data
);

	localparam int RW = ece_pkg::RAD_W;

	logic           v_q;
	ece_pkg::cell_t data_q;
	ece_pkg::cell_t nxt;
	logic [RW:0]    trial;

	assign up_stall = v_q && dn_stall;

	always_comb begin
		trial = (RW+1)'(up_data.root) + (RW+1)'(step_bit);
		nxt   = up_data;
		if ((RW+1)'(up_data.rem) >= trial) begin
			nxt.rem  = RW'((RW+1)'(up_data.rem) - trial);
			nxt.root = RW'((up_data.root >> 1) + step_bit);
		end else begin
			nxt.root = up_data.root >> 1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_q <= 1'b0;
		end else if (!up_stall) begin
			v_q <= up_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (!up_stall && up_valid) begin
			data_q <= nxt;
		end
	end

	assign dn_valid = v_q;
	assign dn_data  = data_q;

endmodule

// ===== rtl/core/easing_curve_evaluator.sv =====
// Easing curve evaluator top level: configuration register, front pipeline,
// square-root cell chain and output register.
// Depends on ece_pkg, ece_front and ece_sqrt_cell.
//
//   Channel   Signals                               Direction  Payload
//   time      time_valid, time_stall                in         progress_time
//   ease      ease_valid, ease_stall                out        eased_value
//   config    psel, penable, pwrite, paddr, pwdata  in         curve_mode at address 0
//
// One request enters per cycle while time_stall is low; each result passes through
// five front stages, fifteen square-root cells and the output register.
// The square-root chain sets the latency; the table, multipliers and chain are all pipelined.
// Reset clears every valid bit and sets the curve to linear; no clearing pass is needed.
// A stall on the output fills empty stages first and reaches time_stall only when full.
module easing_curve_evaluator (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          time_valid,
	output logic                          time_stall,
	input  logic [ece_pkg::FIELD_W-1:0]   progress_time,
	output logic                          ease_valid,
	input  logic                          ease_stall,
	output logic [ece_pkg::FIELD_W-1:0]   eased_value,
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [ece_pkg::CFG_AW-1:0]    paddr,
	input  logic [31:0]                   pwdata,
	output logic [31:0]                   prdata,
	output logic                          pready
);

	localparam int N  = ece_pkg::ROOT_STEPS;
	localparam int RW = ece_pkg::RAD_W;
	localparam int W  = ece_pkg::FIELD_W;

	logic [2:0]     mode_q;
	logic           ch_valid [0:N];
	logic           ch_stall [0:N];
	ece_pkg::cell_t ch_data  [0:N];

	logic           out_v_q;
	logic [W-1:0]   out_q;
	logic           tail_stall;
	logic [RW:0]    arc_sum;
	logic [W-1:0]   final_n;

	assign pready = 1'b1;
	assign prdata = (paddr[2] == 1'b0) ? {29'd0, mode_q} : 32'd0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= ece_pkg::CURVE_LINEAR;
		end else if (psel && penable && pwrite && pready && (paddr[2] == 1'b0)) begin
			mode_q <= pwdata[2:0];
		end
	end

	ece_front u_front (
		.clk           (clk),
		.arst_n        (arst_n),
		.time_valid    (time_valid),
		.time_stall    (time_stall),
		.progress_time (progress_time),
		.curve_mode    (mode_q),
		.cell_valid    (ch_valid[0]),
		.cell_stall    (ch_stall[0]),
		.cell_data     (ch_data[0])
	);

	for (genvar i = 0; i < N; i++) begin : g_cell
		ece_sqrt_cell u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.step_bit (RW'(1) << (RW - 2 - 2 * i)),
			.up_valid (ch_valid[i]),
			.up_stall (ch_stall[i]),
			.up_data  (ch_data[i]),
			.dn_valid (ch_valid[i+1]),
			.dn_stall (ch_stall[i+1]),
			.dn_data  (ch_data[i+1])
		);
	end

	assign tail_stall = out_v_q && ease_stall;
	assign ch_stall[N] = tail_stall;

	always_comb begin
		arc_sum = (RW+1)'(ch_data[N].root) + (RW+1)'(ece_pkg::BOUNCE_OFS);
		if (!ch_data[N].use_sqrt) begin
			final_n = ch_data[N].result;
		end else if (arc_sum > (RW+1)'(ece_pkg::OUT_MAX)) begin
			final_n = ece_pkg::OUT_MAX;
		end else begin
			final_n = W'(arc_sum);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_q <= 1'b0;
		end else if (!tail_stall) begin
			out_v_q <= ch_valid[N];
		end
	end

	always_ff @(posedge clk) begin
		if (!tail_stall && ch_valid[N]) begin
			out_q <= final_n;
		end
	end

	assign ease_valid  = out_v_q;
	assign eased_value = out_q;

endmodule

// ===== tb/sv/easing_curve_evaluator_tb.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for easing_curve_evaluator: time requests go in through a
// valid/stall driver, eased values are checked against a built-in curve predictor.
// Depends on ece_pkg and the easing_curve_evaluator RTL.
module easing_curve_evaluator_tb;

	localparam int          FRAC        = 16;
	localparam int          TAB_DEPTH   = 256;
	localparam logic [63:0] UNIT        = 64'd1 << FRAC;
	localparam logic [63:0] HALF_UNIT   = 64'd1 << (FRAC - 1);
	localparam logic [63:0] THREE_QTR   = 64'd3 << (FRAC - 2);
	localparam logic [63:0] RADIUS_SQ   = 64'd5 << (2 * FRAC - 6);
	localparam logic [63:0] ARC_BASE    = 64'd7 << (FRAC - 3);
	localparam logic [63:0] FIELD_MAX   = 64'h1FFFF;
	localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;

	localparam logic [2:0] CURVE_RESERVED_A = 3'd6;
	localparam logic [2:0] CURVE_RESERVED_B = 3'd7;

	localparam logic [ece_pkg::CFG_AW-1:0] ADDR_CURVE_MODE = 3'd0;
	localparam logic [ece_pkg::CFG_AW-1:0] ADDR_SPARE      = 3'd4;

	localparam int ITEMS_PER_BLOCK   = 42;
	localparam int BLOCKS_PER_PHASE  = 10;
	localparam int LONG_HOLD_CYCLES  = 300;
	localparam int DRAIN_CYCLES      = 40;
	localparam int RUN_LIMIT_NS      = 3000000;

	logic                         clk           = 1'b0;
	logic                         arst_n        = 1'b0;
	logic                         time_valid    = 1'b0;
	logic                         time_stall;
	logic [ece_pkg::FIELD_W-1:0]  progress_time = '0;
	logic                         ease_valid;
	logic                         ease_stall    = 1'b0;
	logic [ece_pkg::FIELD_W-1:0]  eased_value;
	logic                         psel          = 1'b0;
	logic                         penable       = 1'b0;
	logic                         pwrite        = 1'b0;
	logic [ece_pkg::CFG_AW-1:0]   paddr         = '0;
	logic [31:0]                  pwdata        = '0;
	logic [31:0]                  prdata;
	logic                         pready;

	logic [ece_pkg::FIELD_W-1:0]  pending_times[$];
	logic [ece_pkg::FIELD_W-1:0]  expected_eases[$];
	logic [ece_pkg::FIELD_W-1:0]  oldest_ease;
	logic [2:0]                   curve_setting  = ece_pkg::CURVE_LINEAR;
	int                           send_idle_pct  = 0;
	int                           recv_idle_pct  = 0;
	logic                         long_hold      = 1'b0;
	logic                         long_hold_req  = 1'b0;
	int                           fail_count     = 0;
	int                           requests_taken = 0;
	int                           results_checked = 0;
	int                           settings_applied = 0;

	easing_curve_evaluator u_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.time_valid   (time_valid),
		.time_stall   (time_stall),
		.progress_time(progress_time),
		.ease_valid   (ease_valid),
		.ease_stall   (ease_stall),
		.eased_value  (eased_value),
		.psel         (psel),
		.penable      (penable),
		.pwrite       (pwrite),
		.paddr        (paddr),
		.pwdata       (pwdata),
		.prdata       (prdata),
		.pready       (pready)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	initial begin
		#(RUN_LIMIT_NS);
		$display("Some tests failed");
		$finish;
	end

	function automatic logic [63:0] root_floor(logic [63:0] v);
		logic [63:0] res;
		logic [63:0] bitpos;
		res    = 64'd0;
		bitpos = 64'd1 << 62;
		while (bitpos > v) bitpos = bitpos >> 2;
		while (bitpos != 64'd0) begin
			if (v >= res + bitpos) begin
				v   = v - (res + bitpos);
				res = (res >> 1) + bitpos;
			end else begin
				res = res >> 1;
			end
			bitpos = bitpos >> 2;
		end
		return res;
	endfunction

	function automatic logic [63:0] quarter_sine(logic [63:0] k);
		logic [63:0]        x;
		logic [63:0]        x2;
		logic [63:0]        term;
		logic signed [63:0] acc;
		if (k > TAB_DEPTH) k = TAB_DEPTH;
		x    = (HALF_PI_Q30 * k) / TAB_DEPTH;
		x2   = (x * x) >> 30;
		term = x;
		acc  = signed'(x);
		for (int n = 1; n <= 8; n++) begin
			term = ((term * x2) >> 30) / (64'(2 * n) * 64'(2 * n + 1));
			if (n % 2 == 1) begin
				acc = acc - signed'(term);
			end else begin
				acc = acc + signed'(term);
			end
		end
		if (acc < 0) acc = 0;
		return (unsigned'(acc) + (64'd1 << (29 - FRAC))) >> (30 - FRAC);
	endfunction

	function automatic logic [63:0] sine_ease(logic [63:0] t);
		logic [63:0] offset;
		logic [63:0] pos;
		logic [63:0] k;
		logic [63:0] f;
		logic [63:0] e0;
		logic [63:0] e1;
		logic [63:0] diff;
		logic [63:0] s;
		offset = (t >= HALF_UNIT) ? t - HALF_UNIT : HALF_UNIT - t;
		pos  = offset * 2 * TAB_DEPTH;
		k    = pos >> FRAC;
		f    = pos & (UNIT - 1);
		e0   = quarter_sine(k);
		e1   = (k >= TAB_DEPTH) ? e0 : quarter_sine(k + 1);
		diff = (e1 >= e0) ? e1 - e0 : 64'd0;
		s    = e0 + ((diff * f + HALF_UNIT) >> FRAC);
		if (s > UNIT) s = UNIT;
		if (t >= HALF_UNIT) return (UNIT + s + 1) >> 1;
		return (UNIT - s + 1) >> 1;
	endfunction

	function automatic logic [ece_pkg::FIELD_W-1:0] eased_for(
		logic [ece_pkg::FIELD_W-1:0] t_in,
		logic [2:0]                  mode
	);
		logic [63:0] t;
		logic [63:0] r;
		logic [63:0] d;
		t = 64'(t_in);
		if (t > UNIT) t = UNIT;
		case (ece_pkg::curve_mode_t'(mode))
			ece_pkg::CURVE_CONSTANT: r = UNIT;
			ece_pkg::CURVE_BOUNCE: begin
				if (t < HALF_UNIT) begin
					r = 2 * t;
				end else begin
					d = (t >= THREE_QTR) ? t - THREE_QTR : THREE_QTR - t;
					r = root_floor((RADIUS_SQ > d * d) ? RADIUS_SQ - d * d : 64'd0) + ARC_BASE;
				end
			end
			ece_pkg::CURVE_FADE_IN:     r = (t * t + HALF_UNIT) >> FRAC;
			ece_pkg::CURVE_FADE_OUT:    r = (t * (2 * UNIT - t) + HALF_UNIT) >> FRAC;
			ece_pkg::CURVE_FADE_IN_OUT: r = sine_ease(t);
			default:                    r = t;
		endcase
		if (r > FIELD_MAX) r = FIELD_MAX;
		return r[ece_pkg::FIELD_W-1:0];
	endfunction

	function automatic logic [ece_pkg::FIELD_W-1:0] random_time();
		logic [ece_pkg::FIELD_W-1:0] base;
		int                          pick;
		pick = $urandom_range(0, 99);
		if (pick < 60) return ece_pkg::FIELD_W'($urandom_range(0, 65536));
		if (pick < 80) return ece_pkg::FIELD_W'($urandom_range(0, 17'h1FFFF));
		case ($urandom_range(0, 4))
			0:       base = 17'h00000;
			1:       base = 17'h08000;
			2:       base = 17'h0C000;
			3:       base = 17'h10000;
			default: base = 17'h1FFFF;
		endcase
		return base + ece_pkg::FIELD_W'($urandom_range(0, 4)) - 17'd2;
	endfunction

	always @(posedge clk) begin
		if (!arst_n) begin
			time_valid <= 1'b0;
		end else begin
			if (time_valid && !time_stall) begin
				expected_eases.push_back(eased_for(progress_time, curve_setting));
				void'(pending_times.pop_front());
				requests_taken++;
			end
			if (!time_valid || !time_stall) begin
				if (pending_times.size() > 0 && $urandom_range(0, 99) >= send_idle_pct) begin
					time_valid    <= 1'b1;
					progress_time <= pending_times[0];
				end else begin
					time_valid <= 1'b0;
				end
			end
		end
	end

	always @(posedge clk) begin
		if (!arst_n) begin
			ease_stall <= 1'b0;
		end else begin
			if (ease_valid && !ease_stall) begin
				if (expected_eases.size() == 0) begin
					$error("eased_value %0d arrived with no request outstanding", eased_value);
					fail_count++;
				end else begin
					oldest_ease = expected_eases.pop_front();
					results_checked++;
					if (eased_value !== oldest_ease) begin
						$error("eased_value mismatch: expected %0d, got %0d", oldest_ease, eased_value);
						fail_count++;
					end
				end
			end
			ease_stall <= long_hold || ($urandom_range(0, 99) < recv_idle_pct);
		end
	end

	initial begin
		wait (long_hold_req);
		@(posedge clk);
		long_hold <= 1'b1;
		repeat (LONG_HOLD_CYCLES) @(posedge clk);
		long_hold <= 1'b0;
	end

	task automatic wait_drained();
		do @(negedge clk);
		while (pending_times.size() != 0 || expected_eases.size() != 0 || time_valid);
	endtask

	task automatic apb_write(input logic [ece_pkg::CFG_AW-1:0] addr, input logic [31:0] data);
		@(posedge clk);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= addr;
		pwdata  <= data;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk);
		while (!pready);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
	endtask

	task automatic check_curve_readback();
		@(posedge clk);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		paddr   <= ADDR_CURVE_MODE;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk);
		while (!pready);
		if (prdata !== 32'(curve_setting)) begin
			$error("curve_mode readback mismatch: expected %0d, got %0d", curve_setting, prdata);
			fail_count++;
		end
		psel    <= 1'b0;
		penable <= 1'b0;
	endtask

	task automatic apply_curve(input logic [2:0] mode);
		wait_drained();
		apb_write(ADDR_CURVE_MODE, 32'(mode));
		curve_setting = mode;
		settings_applied++;
		check_curve_readback();
		@(negedge clk);
	endtask

	task automatic offer(input logic [ece_pkg::FIELD_W-1:0] t);
		pending_times.push_back(t);
	endtask

	initial begin
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;

		check_curve_readback();
		@(negedge clk);
		offer(17'h00000);
		offer(17'h00001);
		offer(17'h10001);
		offer(17'h1FFFF);

		apply_curve(ece_pkg::CURVE_CONSTANT);
		offer(17'h00000);
		offer(17'h1FFFF);

		apply_curve(ece_pkg::CURVE_BOUNCE);
		offer(17'h07FFF);
		offer(17'h08000);
		offer(17'h0C000);
		offer(17'h10000);

		// A write to an address other than curve_mode must leave the curve alone.
		apply_curve(ece_pkg::CURVE_FADE_IN);
		apb_write(ADDR_SPARE, 32'(ece_pkg::CURVE_FADE_OUT));
		check_curve_readback();
		@(negedge clk);
		offer(17'h0FFFF);
		offer(17'h10000);

		apply_curve(ece_pkg::CURVE_FADE_OUT);
		offer(17'h00000);
		offer(17'h08000);
		offer(17'h1FFFF);

		apply_curve(ece_pkg::CURVE_FADE_IN_OUT);
		offer(17'h00000);
		offer(17'h07FFF);
		offer(17'h08000);
		offer(17'h08001);
		offer(17'h10000);

		apply_curve(CURVE_RESERVED_A);
		offer(17'h04321);
		offer(17'h10001);

		apply_curve(CURVE_RESERVED_B);
		offer(17'h1ABCD);

		for (int phase = 0; phase < 3; phase++) begin
			case (phase)
				0: begin
					send_idle_pct = 10;
					recv_idle_pct = 79;
				end
				1: begin
					send_idle_pct = 79;
					recv_idle_pct = 10;
				end
				default: begin
					send_idle_pct = 0;
					recv_idle_pct = 0;
				end
			endcase
			for (int blk = 0; blk < BLOCKS_PER_PHASE; blk++) begin
				apply_curve(3'($urandom_range(0, 7)));
				for (int i = 0; i < ITEMS_PER_BLOCK; i++) offer(random_time());
				if (phase == 2 && blk == 0) long_hold_req = 1'b1;
			end
		end

		wait_drained();
		repeat (DRAIN_CYCLES) @(posedge clk);
		$display("Run covered %0d time requests under %0d curve settings; %0d results checked.",
			requests_taken, settings_applied, results_checked);
		$display("Both channels idled at random, and one long output stall backed up the input.");
		if (fail_count == 0) begin
			$display("All tests passed");
		end else begin
			$display("Some tests failed");
		end
		$finish;
	end

endmodule

// ===== files.f =====
rtl/core/ece_pkg.sv
rtl/core/ece_front.sv
rtl/core/ece_sqrt_cell.sv
rtl/core/easing_curve_evaluator.sv
tb/sv/easing_curve_evaluator_tb.sv
